[sv/sslrd_pkg.sv]
// sslrd_pkg: shared types and constants for the sprite scanline RLE decoder.
// Holds result kinds, pending operation codes, command nibbles and field widths.
// No dependencies.
package sslrd_pkg;

  localparam int BYTE_W  = 8;
  localparam int RUN_W   = 12;
  localparam int TOTAL_W = 16;
  localparam int KIND_W  = 3;
  localparam int NIB_W   = 4;
  // pixel_value + run_length + line_pixels = 36 bits, padded to 40
  localparam int OUT_DATA_W = 40;

  typedef enum logic [KIND_W-1:0] {
    KIND_PIXEL = 3'd0,
    KIND_FILL  = 3'd1,
    KIND_SKIP  = 3'd2,
    KIND_END   = 3'd3,
    KIND_ERROR = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    OP_COPY = 2'd0,
    OP_SKIP = 2'd1,
    OP_FILL = 2'd2,
    OP_ZERO = 2'd3
  } op_t;

  // low two bits of a command byte
  localparam logic [1:0] LOW2_SHORT_COPY = 2'b00;
  localparam logic [1:0] LOW2_SHORT_SKIP = 2'b01;

  // low nibble of a command byte
  localparam logic [NIB_W-1:0] NIB_LONG_COPY = 4'h2;
  localparam logic [NIB_W-1:0] NIB_LONG_SKIP = 4'h3;
  localparam logic [NIB_W-1:0] NIB_COPY      = 4'h6;
  localparam logic [NIB_W-1:0] NIB_FILL_A    = 4'h7;
  localparam logic [NIB_W-1:0] NIB_FILL_B    = 4'ha;
  localparam logic [NIB_W-1:0] NIB_ZERO_FILL = 4'hb;
  localparam logic [NIB_W-1:0] NIB_EXTENDED  = 4'he;
  localparam logic [NIB_W-1:0] NIB_END       = 4'hf;

  // high nibble of extended commands
  localparam logic [NIB_W-1:0] EXT_ERROR_MAX = 4'h3;
  localparam logic [NIB_W-1:0] EXT_PIXEL_A   = 4'h4;
  localparam logic [NIB_W-1:0] EXT_ZFILL_A   = 4'h5;
  localparam logic [NIB_W-1:0] EXT_PIXEL_B   = 4'h6;
  localparam logic [NIB_W-1:0] EXT_ZFILL_B   = 4'h7;

endpackage

[sv/sprite_scanline_rle_decoder_top.sv]
// sprite_scanline_rle_decoder_top: byte-serial decoder for run-length coded
// sprite scanlines. Depends on sslrd_pkg.
//
// Each result is held in the output register from the cycle after the byte
// that causes it is transferred in. Throughput: one byte per cycle while
// s_tready is high; the parser state and the output register are the only
// storage on the path. s_tready drops only while a result waits in the
// output register and the sink is stalled. Reset (rst, synchronous, active
// high) returns the parser to expect a command byte, clears counts and the
// pixel total, and empties the output register.
module sprite_scanline_rle_decoder_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [sslrd_pkg::BYTE_W-1:0]         s_tdata,  // [7:0] code_byte
  input  logic                                 s_tuser,  // [0] line_start
  // result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [7:0] pixel_value, [19:8] run_length, [35:20] line_pixels, [39:36] zero
  output logic [sslrd_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic [sslrd_pkg::KIND_W-1:0]         m_tuser   // [2:0] kind
);

  typedef enum logic [2:0] {
    PH_CMD   = 3'd0,
    PH_CNTLO = 3'd1,
    PH_CNT   = 3'd2,
    PH_COLOR = 3'd3,
    PH_LIT   = 3'd4
  } phase_t;

  // parser state
  phase_t                             phase;
  sslrd_pkg::op_t                     pending_op;
  logic [sslrd_pkg::RUN_W-1:0]        remaining_count;
  logic [sslrd_pkg::NIB_W-1:0]        high_count_bits;
  logic [sslrd_pkg::TOTAL_W-1:0]      pixel_total;

  // next values
  phase_t                             phase_next;
  sslrd_pkg::op_t                     pending_op_next;
  logic [sslrd_pkg::RUN_W-1:0]        remaining_count_next;
  logic [sslrd_pkg::NIB_W-1:0]        high_count_bits_next;
  logic [sslrd_pkg::TOTAL_W-1:0]      pixel_total_next;

  // result of the current byte
  logic                               res_valid;
  sslrd_pkg::kind_t                   res_kind;
  logic [sslrd_pkg::BYTE_W-1:0]       res_pix;
  logic [sslrd_pkg::RUN_W-1:0]        res_len;
  logic [sslrd_pkg::TOTAL_W-1:0]      res_tot;

  // pixel-total update, one saturating adder shared by all cases
  logic                               add_en;
  logic [sslrd_pkg::RUN_W-1:0]        add_amt;
  logic [sslrd_pkg::TOTAL_W:0]        add_sum;

  logic                               in_xfer;
  logic [sslrd_pkg::BYTE_W-1:0]       b;
  logic [sslrd_pkg::NIB_W-1:0]        top;
  logic [sslrd_pkg::NIB_W-1:0]        nib;

  assign s_tready = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;
  assign b        = s_tdata;
  assign top      = b[7:4];
  assign nib      = b[3:0];

  always_comb begin
    phase_next           = phase;
    pending_op_next      = pending_op;
    remaining_count_next = remaining_count;
    high_count_bits_next = high_count_bits;
    pixel_total_next     = pixel_total;

    res_valid = 1'b0;
    res_kind  = sslrd_pkg::KIND_PIXEL;
    res_pix   = '0;
    res_len   = '0;
    res_tot   = '0;
    add_en    = 1'b0;
    add_amt   = '0;

    // line_start drops any command in progress
    if (s_tuser) begin
      phase_next           = PH_CMD;
      pending_op_next      = sslrd_pkg::OP_COPY;
      remaining_count_next = '0;
      high_count_bits_next = '0;
      pixel_total_next     = '0;
    end

    case (phase_next)
      PH_CNTLO: begin
        if (pending_op_next == sslrd_pkg::OP_COPY) begin
          remaining_count_next = {high_count_bits_next, b};
          phase_next = ({high_count_bits_next, b} != '0) ? PH_LIT : PH_CMD;
        end else begin
          res_valid  = 1'b1;
          res_kind   = sslrd_pkg::KIND_SKIP;
          res_len    = {high_count_bits_next, b};
          add_en     = 1'b1;
          add_amt    = {high_count_bits_next, b};
          phase_next = PH_CMD;
        end
      end
      PH_CNT: begin
        if (pending_op_next == sslrd_pkg::OP_COPY) begin
          remaining_count_next = {4'd0, b};
          phase_next = (b != '0) ? PH_LIT : PH_CMD;
        end else if (pending_op_next == sslrd_pkg::OP_FILL) begin
          remaining_count_next = {4'd0, b};
          phase_next           = PH_COLOR;
        end else begin
          res_valid  = 1'b1;
          res_kind   = sslrd_pkg::KIND_FILL;
          res_len    = {4'd0, b};
          add_en     = 1'b1;
          add_amt    = {4'd0, b};
          phase_next = PH_CMD;
        end
      end
      PH_COLOR: begin
        res_valid  = 1'b1;
        res_kind   = sslrd_pkg::KIND_FILL;
        res_pix    = b;
        res_len    = remaining_count_next;
        add_en     = 1'b1;
        add_amt    = remaining_count_next;
        phase_next = PH_CMD;
      end
      PH_LIT: begin
        res_valid            = 1'b1;
        res_kind             = sslrd_pkg::KIND_PIXEL;
        res_pix              = b;
        add_en               = 1'b1;
        add_amt              = 12'd1;
        remaining_count_next = remaining_count_next - 12'd1;
        if (remaining_count_next == '0) begin
          phase_next = PH_CMD;
        end
      end
      default: begin
        // command byte; unused phase codes land here too
        phase_next = PH_CMD;
        if (b[1:0] == sslrd_pkg::LOW2_SHORT_COPY) begin
          remaining_count_next = {6'd0, b[7:2]};
          phase_next = (b[7:2] != '0) ? PH_LIT : PH_CMD;
        end else if (b[1:0] == sslrd_pkg::LOW2_SHORT_SKIP) begin
          res_valid = 1'b1;
          res_kind  = sslrd_pkg::KIND_SKIP;
          res_len   = {6'd0, b[7:2]};
          add_en    = 1'b1;
          add_amt   = {6'd0, b[7:2]};
        end else begin
          case (nib)
            sslrd_pkg::NIB_LONG_COPY, sslrd_pkg::NIB_LONG_SKIP: begin
              high_count_bits_next = top;
              pending_op_next = (nib == sslrd_pkg::NIB_LONG_COPY) ?
                                sslrd_pkg::OP_COPY : sslrd_pkg::OP_SKIP;
              phase_next = PH_CNTLO;
            end
            sslrd_pkg::NIB_COPY: begin
              if (top == '0) begin
                pending_op_next = sslrd_pkg::OP_COPY;
                phase_next      = PH_CNT;
              end else begin
                remaining_count_next = {8'd0, top};
                phase_next           = PH_LIT;
              end
            end
            sslrd_pkg::NIB_FILL_A, sslrd_pkg::NIB_FILL_B: begin
              pending_op_next = sslrd_pkg::OP_FILL;
              if (top == '0) begin
                phase_next = PH_CNT;
              end else begin
                remaining_count_next = {8'd0, top};
                phase_next           = PH_COLOR;
              end
            end
            sslrd_pkg::NIB_ZERO_FILL: begin
              if (top == '0) begin
                pending_op_next = sslrd_pkg::OP_ZERO;
                phase_next      = PH_CNT;
              end else begin
                res_valid = 1'b1;
                res_kind  = sslrd_pkg::KIND_FILL;
                res_len   = {8'd0, top};
                add_en    = 1'b1;
                add_amt   = {8'd0, top};
              end
            end
            sslrd_pkg::NIB_EXTENDED: begin
              if (top <= sslrd_pkg::EXT_ERROR_MAX) begin
                res_valid        = 1'b1;
                res_kind         = sslrd_pkg::KIND_ERROR;
                pixel_total_next = '0;
              end else if (top inside {sslrd_pkg::EXT_PIXEL_A,
                                       sslrd_pkg::EXT_PIXEL_B}) begin
                res_valid = 1'b1;
                res_kind  = sslrd_pkg::KIND_PIXEL;
                add_en    = 1'b1;
                add_amt   = 12'd1;
              end else if (top inside {sslrd_pkg::EXT_ZFILL_A,
                                       sslrd_pkg::EXT_ZFILL_B}) begin
                pending_op_next = sslrd_pkg::OP_ZERO;
                phase_next      = PH_CNT;
              end
            end
            sslrd_pkg::NIB_END: begin
              res_valid        = 1'b1;
              res_kind         = sslrd_pkg::KIND_END;
              res_tot          = pixel_total_next;
              pixel_total_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
    endcase

    // saturating pixel total
    add_sum = {1'b0, pixel_total_next} + {{(sslrd_pkg::TOTAL_W+1-sslrd_pkg::RUN_W){1'b0}},
                                          add_amt};
    if (add_en) begin
      pixel_total_next = add_sum[sslrd_pkg::TOTAL_W] ? '1
                                                     : add_sum[sslrd_pkg::TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_CMD;
      pending_op      <= sslrd_pkg::OP_COPY;
      remaining_count <= '0;
      high_count_bits <= '0;
      pixel_total     <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase           <= phase_next;
        pending_op      <= pending_op_next;
        remaining_count <= remaining_count_next;
        high_count_bits <= high_count_bits_next;
        pixel_total     <= pixel_total_next;
        m_tvalid        <= res_valid;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // output payload, loaded with each input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      m_tuser <= res_kind;
      m_tdata <= {4'd0, res_tot, res_len, res_pix};
    end
  end

endmodule
